[src/ubrq_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the serial port byte ring queues
// no dependencies; used by the top unit and ubrq_ctrl

package ubrq_pkg;

	// default ring depths, one slot of each ring always stays empty
	localparam int RxDepthDef  = 128;
	localparam int TxDepthDef  = 128;

	// longest read request that is served
	localparam int ResultLimit = 64;
	localparam int RemW        = $clog2(ResultLimit + 1);

	localparam int ByteW       = 8;

	// operation codes of an input transaction
	typedef enum logic [1:0] {
		OP_LINE_RX  = 2'd0,
		OP_TX_READY = 2'd1,
		OP_READ     = 2'd2,
		OP_WRITE    = 2'd3
	} ubrq_op_t;

	// status codes of a result transaction
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REFUSED  = 2'd1,
		ST_DROPPED  = 2'd2,
		ST_TX_EMPTY = 2'd3
	} ubrq_status_t;

	// input transaction
	typedef struct packed {
		logic [1:0]       opcode;
		logic [ByteW-1:0] data;
		logic [ByteW-1:0] count;
		logic             first;
	} ubrq_req_t;

	// result transaction
	typedef struct packed {
		logic [ByteW-1:0] byte_out;
		logic [1:0]       status;
		logic             last;
		logic             tx_request;
		logic [ByteW-1:0] rx_pending;
		logic [ByteW-1:0] tx_space;
	} ubrq_rsp_t;

endpackage

[src/uart_byte_ring_queues_unit.sv]
`timescale 1ns / 1ps
// Receive and transmit byte ring queues of a serial port. Each queue keeps one
// slot empty and so holds depth minus one bytes. Every input transaction gives
// at least one result; a read request for N bytes gives N results, the last one
// marked. A single-result transaction passes through the stage-one register and
// the result register. A read of N bytes streams one byte per cycle, while the
// output is not stalled, from the single read port of the receive memory after a
// set-up step; the next input transaction is taken once the last byte's read has
// been issued. A result waiting on a stalled output holds back at most one
// further result. No clearing pass after reset.
// depends on ubrq_pkg, ubrq_ram and ubrq_ctrl

module uart_byte_ring_queues_unit import ubrq_pkg::*; #(
	parameter int RX_DEPTH = RxDepthDef,
	parameter int TX_DEPTH = TxDepthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  ubrq_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ubrq_rsp_t rsp
);

	localparam int RXW = $clog2(RX_DEPTH);
	localparam int TXW = $clog2(TX_DEPTH);

	logic             rx_we, rx_re, tx_we, tx_re;
	logic [RXW-1:0]   rx_waddr, rx_raddr;
	logic [TXW-1:0]   tx_waddr, tx_raddr;
	logic [ByteW-1:0] rx_wdata, rx_rdata, tx_wdata, tx_rdata;

	// receive queue storage
	ubrq_ram #(
		.WIDTH (ByteW),
		.DEPTH (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (rx_wdata),
		.re    (rx_re),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	// transmit queue storage
	ubrq_ram #(
		.WIDTH (ByteW),
		.DEPTH (TX_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (tx_wdata),
		.re    (tx_re),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	// pointers, counts, bursts and result sequencing
	ubrq_ctrl #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.rx_we     (rx_we),
		.rx_waddr  (rx_waddr),
		.rx_wdata  (rx_wdata),
		.rx_re     (rx_re),
		.rx_raddr  (rx_raddr),
		.rx_rdata  (rx_rdata),
		.tx_we     (tx_we),
		.tx_waddr  (tx_waddr),
		.tx_wdata  (tx_wdata),
		.tx_re     (tx_re),
		.tx_raddr  (tx_raddr),
		.tx_rdata  (tx_rdata)
	);

endmodule

[src/ubrq_ram.sv]
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module ubrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/ubrq_ctrl.sv]
`timescale 1ns / 1ps
// queue pointers, counts, burst tracking, read streaming and result register
// depends on ubrq_pkg; drives the two queue rams instantiated beside it

module ubrq_ctrl import ubrq_pkg::*; #(
	parameter int RX_DEPTH = RxDepthDef,
	parameter int TX_DEPTH = TxDepthDef,
	localparam int RXW = $clog2(RX_DEPTH),
	localparam int TXW = $clog2(TX_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ubrq_req_t        req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output ubrq_rsp_t        rsp,
	output logic             rx_we,
	output logic [RXW-1:0]   rx_waddr,
	output logic [ByteW-1:0] rx_wdata,
	output logic             rx_re,
	output logic [RXW-1:0]   rx_raddr,
	input  logic [ByteW-1:0] rx_rdata,
	output logic             tx_we,
	output logic [TXW-1:0]   tx_waddr,
	output logic [ByteW-1:0] tx_wdata,
	output logic             tx_re,
	output logic [TXW-1:0]   tx_raddr,
	input  logic [ByteW-1:0] tx_rdata
);

	localparam logic [RXW-1:0] RxLast = RXW'(RX_DEPTH - 1);
	localparam logic [TXW-1:0] TxLast = TXW'(TX_DEPTH - 1);

	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_RX,
		SRC_TX
	} src_t;

	// queue state
	logic [RXW-1:0]   rx_rd_ptr_q, rx_wr_ptr_q, rx_cnt_q;
	logic [TXW-1:0]   tx_rd_ptr_q, tx_wr_ptr_q, tx_free_q;
	logic [ByteW-1:0] burst_left_q;
	logic             burst_refused_q, tx_req_q;
	logic             busy_q;
	logic [RemW-1:0]  rem_q;

	// result waiting on the ram read
	logic             pend_s1;
	src_t             src_s1;
	logic [1:0]       status_s1;
	logic             last_s1;
	logic             tx_request_s1;
	logic [ByteW-1:0] rx_pending_s1, tx_space_s1;

	// result register
	ubrq_rsp_t        rsp_q;
	logic             rsp_vld_q;

	// next state
	logic [RXW-1:0]   rx_rd_ptr_d, rx_wr_ptr_d, rx_cnt_d;
	logic [TXW-1:0]   tx_rd_ptr_d, tx_wr_ptr_d, tx_free_d;
	logic [ByteW-1:0] burst_left_d;
	logic             burst_refused_d, tx_req_d;
	logic             busy_d;
	logic [RemW-1:0]  rem_d;

	logic             s1_adv, s1_free, accept, stream, start_read, s1_load;
	src_t             acc_src;
	logic [1:0]       acc_status;
	logic [RXW-1:0]   rx_rd_nxt, rx_wr_nxt;
	logic [TXW-1:0]   tx_rd_nxt, tx_wr_nxt;
	logic             push_try;
	logic [ByteW-1:0] rsp_byte;

	// handshake and stage movement
	assign s1_adv    = pend_s1 && (!rsp_vld_q || !rsp_stall);
	assign s1_free   = !pend_s1 || s1_adv;
	assign accept    = req_valid && !busy_q && s1_free;
	assign req_stall = busy_q || !s1_free;
	assign stream    = busy_q && s1_free;
	assign s1_load   = (accept && !start_read) || stream;

	// ring successors
	assign rx_rd_nxt = (rx_rd_ptr_q == RxLast) ? '0 : rx_rd_ptr_q + RXW'(1);
	assign rx_wr_nxt = (rx_wr_ptr_q == RxLast) ? '0 : rx_wr_ptr_q + RXW'(1);
	assign tx_rd_nxt = (tx_rd_ptr_q == TxLast) ? '0 : tx_rd_ptr_q + TXW'(1);
	assign tx_wr_nxt = (tx_wr_ptr_q == TxLast) ? '0 : tx_wr_ptr_q + TXW'(1);

	// ram addressing
	assign rx_waddr = rx_wr_nxt;
	assign rx_wdata = req.data;
	assign rx_raddr = rx_rd_nxt;
	assign tx_waddr = tx_wr_nxt;
	assign tx_wdata = req.data;
	assign tx_raddr = tx_rd_nxt;

	// decode of an accepted transaction and the read streaming step
	always_comb begin
		rx_rd_ptr_d     = rx_rd_ptr_q;
		rx_wr_ptr_d     = rx_wr_ptr_q;
		rx_cnt_d        = rx_cnt_q;
		tx_rd_ptr_d     = tx_rd_ptr_q;
		tx_wr_ptr_d     = tx_wr_ptr_q;
		tx_free_d       = tx_free_q;
		burst_left_d    = burst_left_q;
		burst_refused_d = burst_refused_q;
		tx_req_d        = tx_req_q;
		busy_d          = busy_q;
		rem_d           = rem_q;
		rx_we           = 1'b0;
		rx_re           = 1'b0;
		tx_we           = 1'b0;
		tx_re           = 1'b0;
		start_read      = 1'b0;
		push_try        = 1'b0;
		acc_src         = SRC_NONE;
		acc_status      = ST_OK;

		if (accept) begin
			case (req.opcode)
				OP_LINE_RX: begin
					if (rx_cnt_q == RxLast) begin
						acc_status = ST_DROPPED;
					end else begin
						rx_we       = 1'b1;
						rx_wr_ptr_d = rx_wr_nxt;
						rx_cnt_d    = rx_cnt_q + RXW'(1);
					end
				end
				OP_TX_READY: begin
					if (tx_free_q == TxLast) begin
						tx_req_d   = 1'b0;
						acc_status = ST_TX_EMPTY;
					end else begin
						tx_re       = 1'b1;
						tx_rd_ptr_d = tx_rd_nxt;
						tx_free_d   = tx_free_q + TXW'(1);
						acc_src     = SRC_TX;
					end
				end
				OP_READ: begin
					if (req.count > ByteW'(rx_cnt_q) || req.count > ByteW'(ResultLimit)) begin
						acc_status = ST_REFUSED;
					end else if (req.count != '0) begin
						start_read = 1'b1;
						busy_d     = 1'b1;
						rem_d      = req.count[RemW-1:0];
						rx_cnt_d   = rx_cnt_q - RXW'(req.count);
					end
				end
				default: begin
					// write byte, possibly opening a burst
					if (req.first) begin
						if (req.count == '0) begin
							burst_left_d    = '0;
							burst_refused_d = 1'b0;
							tx_req_d        = 1'b1;
						end else if (req.count > ByteW'(tx_free_q)) begin
							burst_refused_d = 1'b1;
							burst_left_d    = req.count - ByteW'(1);
							acc_status      = ST_REFUSED;
						end else begin
							burst_refused_d = 1'b0;
							burst_left_d    = req.count - ByteW'(1);
							push_try        = 1'b1;
						end
					end else if (burst_left_q == '0) begin
						acc_status = ST_REFUSED;
					end else begin
						burst_left_d = burst_left_q - ByteW'(1);
						if (burst_refused_q) begin
							acc_status = ST_REFUSED;
						end else begin
							push_try = 1'b1;
						end
					end
					if (push_try) begin
						if (tx_free_q == '0) begin
							acc_status = ST_REFUSED;
						end else begin
							tx_we       = 1'b1;
							tx_wr_ptr_d = tx_wr_nxt;
							tx_free_d   = tx_free_q - TXW'(1);
							tx_req_d    = 1'b1;
						end
					end
				end
			endcase
		end

		// one receive byte per cycle while a read is streaming
		if (stream) begin
			rx_re       = 1'b1;
			rx_rd_ptr_d = rx_rd_nxt;
			rem_d       = rem_q - RemW'(1);
			if (rem_q == RemW'(1)) begin
				busy_d = 1'b0;
			end
		end
	end

	// queue state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_rd_ptr_q     <= '0;
			rx_wr_ptr_q     <= '0;
			rx_cnt_q        <= '0;
			tx_rd_ptr_q     <= '0;
			tx_wr_ptr_q     <= '0;
			tx_free_q       <= TxLast;
			burst_left_q    <= '0;
			burst_refused_q <= 1'b0;
			tx_req_q        <= 1'b0;
			busy_q          <= 1'b0;
			rem_q           <= '0;
		end else begin
			rx_rd_ptr_q     <= rx_rd_ptr_d;
			rx_wr_ptr_q     <= rx_wr_ptr_d;
			rx_cnt_q        <= rx_cnt_d;
			tx_rd_ptr_q     <= tx_rd_ptr_d;
			tx_wr_ptr_q     <= tx_wr_ptr_d;
			tx_free_q       <= tx_free_d;
			burst_left_q    <= burst_left_d;
			burst_refused_q <= burst_refused_d;
			tx_req_q        <= tx_req_d;
			busy_q          <= busy_d;
			rem_q           <= rem_d;
		end
	end

	// stage one valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (s1_load) begin
			pend_s1 <= 1'b1;
		end else if (s1_adv) begin
			pend_s1 <= 1'b0;
		end
	end

	// stage one payload, summary fields are the state after the step
	always_ff @(posedge clk) begin
		if (s1_load) begin
			tx_request_s1 <= tx_req_d;
			rx_pending_s1 <= ByteW'(rx_cnt_d);
			tx_space_s1   <= ByteW'(tx_free_d);
			if (stream) begin
				src_s1    <= SRC_RX;
				status_s1 <= ST_OK;
				last_s1   <= (rem_q == RemW'(1));
			end else begin
				src_s1    <= acc_src;
				status_s1 <= acc_status;
				last_s1   <= 1'b1;
			end
		end
	end

	// pick the byte from the ram that was read
	always_comb begin
		case (src_s1)
			SRC_RX:  rsp_byte = rx_rdata;
			SRC_TX:  rsp_byte = tx_rdata;
			default: rsp_byte = '0;
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.byte_out   <= rsp_byte;
			rsp_q.status     <= status_s1;
			rsp_q.last       <= last_s1;
			rsp_q.tx_request <= tx_request_s1;
			rsp_q.rx_pending <= rx_pending_s1;
			rsp_q.tx_space   <= tx_space_s1;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

[verif/tb_uart_byte_ring_queues_unit.sv]
`timescale 1ns / 1ps
// testbench for uart_byte_ring_queues_unit: directed corners, ring fill and random traffic
// every result is checked against an in-bench model of both rings; depends on ubrq_pkg

module tb_uart_byte_ring_queues_unit;
	import ubrq_pkg::*;

	localparam int RxDepth     = RxDepthDef;
	localparam int TxDepth     = TxDepthDef;
	localparam int CycleLimit  = 4_000_000;
	localparam int DrainCycles = 40;
	localparam int RandomItems = 30;
	localparam int TxPops      = 16;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	ubrq_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	ubrq_rsp_t rsp;

	// model of both rings
	logic [7:0] rx_ring [RxDepth];
	logic [7:0] tx_ring [TxDepth];
	int         rx_rd;
	int         rx_wr;
	int         rx_cnt;
	int         tx_rd;
	int         tx_wr;
	int         tx_free;
	int         burst_left;
	bit         burst_refused;
	bit         tx_req;

	ubrq_rsp_t  step_out[$];
	ubrq_rsp_t  due_results[$];
	int         n_errors;
	bit         idle_on;
	int         stall_left;
	int         cycle_cnt;

	uart_byte_ring_queues_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	function automatic ubrq_req_t mk_req(input ubrq_op_t op, input logic [7:0] data,
		input logic [7:0] count, input logic first);
		ubrq_req_t r;
		r.opcode = op;
		r.data   = data;
		r.count  = count;
		r.first  = first;
		return r;
	endfunction

	function automatic void add_out(input logic [7:0] b, input ubrq_status_t st);
		ubrq_rsp_t r;
		r = '0;
		r.byte_out = b;
		r.status   = st;
		step_out.push_back(r);
	endfunction

	function automatic bit tx_store_byte(input logic [7:0] b);
		if (tx_free == 0)
			return 1'b0;
		tx_wr = (tx_wr + 1) % TxDepth;
		tx_ring[tx_wr] = b;
		tx_free--;
		tx_req = 1'b1;
		return 1'b1;
	endfunction

	// advance the ring model by one transaction and queue the results it causes
	function automatic void apply_to_queues(input ubrq_req_t r);
		ubrq_rsp_t res;
		step_out.delete();
		case (ubrq_op_t'(r.opcode))
			OP_LINE_RX: begin
				if (rx_cnt >= RxDepth - 1) begin
					add_out(8'h00, ST_DROPPED);
				end else begin
					rx_wr = (rx_wr + 1) % RxDepth;
					rx_ring[rx_wr] = r.data;
					rx_cnt++;
					add_out(8'h00, ST_OK);
				end
			end
			OP_TX_READY: begin
				if (tx_free >= TxDepth - 1) begin
					tx_req = 1'b0;
					add_out(8'h00, ST_TX_EMPTY);
				end else begin
					tx_rd = (tx_rd + 1) % TxDepth;
					tx_free++;
					add_out(tx_ring[tx_rd], ST_OK);
				end
			end
			OP_READ: begin
				if (r.count > rx_cnt || r.count > ResultLimit) begin
					add_out(8'h00, ST_REFUSED);
				end else if (r.count == 0) begin
					add_out(8'h00, ST_OK);
				end else begin
					for (int i = 0; i < r.count; i++) begin
						rx_rd = (rx_rd + 1) % RxDepth;
						rx_cnt--;
						add_out(rx_ring[rx_rd], ST_OK);
					end
				end
			end
			default: begin
				if (r.first) begin
					if (r.count == 0) begin
						burst_left    = 0;
						burst_refused = 1'b0;
						tx_req        = 1'b1;
						add_out(8'h00, ST_OK);
					end else if (r.count > tx_free) begin
						burst_refused = 1'b1;
						burst_left    = r.count - 1;
						add_out(8'h00, ST_REFUSED);
					end else begin
						burst_refused = 1'b0;
						burst_left    = r.count - 1;
						add_out(8'h00, tx_store_byte(r.data) ? ST_OK : ST_REFUSED);
					end
				end else if (burst_left == 0) begin
					add_out(8'h00, ST_REFUSED);
				end else begin
					burst_left--;
					if (burst_refused)
						add_out(8'h00, ST_REFUSED);
					else
						add_out(8'h00, tx_store_byte(r.data) ? ST_OK : ST_REFUSED);
				end
			end
		endcase
		// status fields are taken after the step and shared by all results
		foreach (step_out[i]) begin
			res            = step_out[i];
			res.last       = (i == step_out.size() - 1);
			res.tx_request = tx_req;
			res.rx_pending = rx_cnt[7:0];
			res.tx_space   = tx_free[7:0];
			due_results.push_back(res);
		end
	endfunction

	// offer one transaction, hold it until taken, then update the model
	task automatic push_request(input ubrq_req_t r);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		apply_to_queues(r);
	endtask

	// output back-pressure: random stall runs, no new run starts while idling is off
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap() - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		ubrq_rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (due_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result: byte %02h status %0d", rsp.byte_out, rsp.status);
			end else begin
				want = due_results.pop_front();
				if (rsp.byte_out !== want.byte_out || rsp.status !== want.status ||
					rsp.last !== want.last || rsp.tx_request !== want.tx_request ||
					rsp.rx_pending !== want.rx_pending || rsp.tx_space !== want.tx_space) begin
					n_errors++;
					if (n_errors <= 10) begin
						$write("result mismatch: want byte %02h st %0d last %b req %b rx %0d tx %0d,",
							want.byte_out, want.status, want.last, want.tx_request,
							want.rx_pending, want.tx_space);
						$display(" got byte %02h st %0d last %b req %b rx %0d tx %0d",
							rsp.byte_out, rsp.status, rsp.last, rsp.tx_request,
							rsp.rx_pending, rsp.tx_space);
					end
				end
			end
		end
	end

	// empty rings, zero-length requests, stray and abandoned bursts
	task automatic test_directed_corners();
		idle_on = 1'b1;
		push_request(mk_req(OP_READ, 8'h00, 8'd0, 1'b0));
		push_request(mk_req(OP_READ, 8'hff, 8'd1, 1'b1));
		push_request(mk_req(OP_TX_READY, 8'h00, 8'd0, 1'b0));
		push_request(mk_req(OP_WRITE, 8'hff, 8'hff, 1'b0));
		push_request(mk_req(OP_WRITE, 8'haa, 8'd0, 1'b1));
		push_request(mk_req(OP_TX_READY, 8'hff, 8'hff, 1'b1));
		push_request(mk_req(OP_LINE_RX, 8'h00, 8'h00, 1'b0));
		push_request(mk_req(OP_LINE_RX, 8'hff, 8'hff, 1'b1));
		push_request(mk_req(OP_LINE_RX, 8'h5a, 8'h00, 1'b0));
		push_request(mk_req(OP_LINE_RX, 8'ha5, 8'h80, 1'b0));
		push_request(mk_req(OP_READ, 8'h00, 8'd3, 1'b0));
		push_request(mk_req(OP_READ, 8'h00, 8'd2, 1'b0));
		// new first byte while bursts are still open
		push_request(mk_req(OP_WRITE, 8'hff, 8'd3, 1'b1));
		push_request(mk_req(OP_WRITE, 8'h00, 8'h00, 1'b0));
		push_request(mk_req(OP_WRITE, 8'h81, 8'd2, 1'b1));
		push_request(mk_req(OP_WRITE, 8'h7e, 8'hff, 1'b0));
		push_request(mk_req(OP_WRITE, 8'h11, 8'h00, 1'b0));
		push_request(mk_req(OP_WRITE, 8'hcc, 8'd255, 1'b1));
		push_request(mk_req(OP_WRITE, 8'h22, 8'h00, 1'b0));
		push_request(mk_req(OP_WRITE, 8'h33, 8'd1, 1'b1));
		repeat (6) push_request(mk_req(OP_TX_READY, 8'h00, 8'h00, 1'b0));
		push_request(mk_req(OP_READ, 8'h00, 8'd1, 1'b0));
	endtask

	// fill both rings to the brim, overflow them, drain the receive ring and part of the transmit ring again
	task automatic test_queue_limits();
		for (int i = 0; i < RxDepth + 1; i++)
			push_request(mk_req(OP_LINE_RX, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
		push_request(mk_req(OP_READ, 8'h00, 8'(ResultLimit + 1), 1'b0));
		push_request(mk_req(OP_READ, 8'h00, 8'(ResultLimit), 1'b0));
		push_request(mk_req(OP_READ, 8'h00, 8'(RxDepth - 1 - ResultLimit), 1'b0));
		push_request(mk_req(OP_READ, 8'h00, 8'd1, 1'b0));
		idle_on = 1'b0;
		push_request(mk_req(OP_WRITE, 8'($urandom_range(0, 255)), 8'(TxDepth - 1), 1'b1));
		for (int i = 0; i < TxDepth - 2; i++)
			push_request(mk_req(OP_WRITE, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'b0));
		push_request(mk_req(OP_WRITE, 8'h55, 8'd1, 1'b1));
		idle_on = 1'b1;
		for (int i = 0; i < TxPops; i++)
			push_request(mk_req(OP_TX_READY, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
	endtask

	// mostly well-formed reads and bursts with random content, some noise
	task automatic test_random_traffic();
		int items;
		int sel;
		int n;
		int lim;
		items = 0;
		while (items < RandomItems) begin
			idle_on = ((items / 10) % 3) != 2;
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				push_request(mk_req(OP_LINE_RX, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
				items++;
			end else if (sel < 50) begin
				push_request(mk_req(OP_TX_READY, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
				items++;
			end else if (sel < 70) begin
				lim = (rx_cnt < ResultLimit) ? rx_cnt : ResultLimit;
				if ($urandom_range(0, 9) == 0)
					n = $urandom_range(0, 255);
				else if ($urandom_range(0, 4) == 0)
					n = $urandom_range(0, lim);
				else
					n = $urandom_range(0, (lim < 6) ? lim : 6);
				push_request(mk_req(OP_READ, 8'($urandom_range(0, 255)), 8'(n),
					1'($urandom_range(0, 1))));
				items++;
			end else if (sel < 95) begin
				case ($urandom_range(0, 9))
					0: n = 0;
					1: n = $urandom_range(0, 255);
					default: n = $urandom_range(1, 6);
				endcase
				push_request(mk_req(OP_WRITE, 8'($urandom_range(0, 255)), 8'(n), 1'b1));
				items++;
				// burst body, sometimes cut short or interleaved with a pop
				for (int i = 1; i < n && i < 7; i++) begin
					if ($urandom_range(0, 19) == 0)
						break;
					if ($urandom_range(0, 7) == 0) begin
						push_request(mk_req(OP_TX_READY, 8'h00, 8'h00, 1'b0));
						items++;
					end
					push_request(mk_req(OP_WRITE, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 1'b0));
					items++;
				end
			end else begin
				push_request(mk_req(OP_WRITE, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b0));
				items++;
			end
		end
	endtask

	// watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		n_errors      = 0;
		idle_on       = 1'b0;
		stall_left    = 0;
		rx_rd         = 0;
		rx_wr         = 0;
		rx_cnt        = 0;
		tx_rd         = 0;
		tx_wr         = 0;
		tx_free       = TxDepth - 1;
		burst_left    = 0;
		burst_refused = 1'b0;
		tx_req        = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_corners();
		test_queue_limits();
		test_random_traffic();
		req_valid <= 1'b0;

		// let the block drain, then watch a little longer for stray results
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
